// File: design/stc_pkg.sv
// Shared types, constants and helpers for the super-twisting controller.
// Depends on nothing; used by stc_ctrl, stc_dp and the top level.
package stc_pkg;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_SETPOINT      = 3'd0;
	localparam logic [2:0] REG_GAIN_P        = 3'd1;
	localparam logic [2:0] REG_GAIN_D        = 3'd2;
	localparam logic [2:0] REG_OFFSET        = 3'd3;
	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd4;

	localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd655;

	// Root has 28 bits (radicand of 56 bits); step dividend has 28 bits
	localparam int ROOT_W     = 28;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int DIV_W      = 28;
	localparam int ITER_STEPS = 28;
	localparam int CNT_W      = 5;

	// Rounding bias for the Q.24 -> Q.16 step, scaled by ten
	localparam logic [35:0] STEP_BIAS = 36'd1280;

	// Divide by ten as multiply by ceil(2^31 / 10) and shift; exact below 2^30
	localparam logic [27:0] RECIP_TEN   = 28'hCCC_CCCD;
	localparam int          RECIP_SHIFT = 31;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SIGMA = 6'b000010,
		ST_PREP  = 6'b000100,
		ST_ITER  = 6'b001000,
		ST_UPDW  = 6'b010000,
		ST_DRIVE = 6'b100000
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_angle;
		logic calc_sigma;
		logic prep;
		logic iterate;
		logic update_w;
		logic load_out;
	} cmd_t;

	// Clamp a 35-bit signed value to the signed 32-bit range
	function automatic logic [31:0] sat35(input logic signed [34:0] v);
		logic signed [34:0] hi;
		logic signed [34:0] lo;
		hi = 35'sh0_7FFF_FFFF;
		lo = -35'sh0_8000_0000;
		if (v > hi) begin
			return 32'h7FFF_FFFF;
		end else if (v < lo) begin
			return 32'h8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

// File: design/super_twisting_controller.sv
// Top level of the single-axis super-twisting sliding-mode controller.
// Instantiates stc_ctrl and stc_dp; depends on stc_pkg.
//
//   channel  signals                              direction
//   input    in_valid, in_stall, measured_angle    angle in
//   output   out_valid, out_stall, drive_value,    result out
//            sliding_value
//   config   cfg_we, cfg_index, cfg_data           register write
//
// A sample runs from taking the angle through the sigma and prep setup
// states, one iteration of the bit-serial root per root bit (the divide
// by ten for the integral step settles alongside), the integral update
// and the output load, after which the next angle can be taken.
// Reset initialises the state machine, output valid, config registers and integral term.
// A held result stalls only the output load; the next angle waits until then.
module super_twisting_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  measured_angle,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  drive_value,
	output logic signed [31:0]  sliding_value
);

	stc_pkg::cmd_t cmd;

	stc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	stc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.measured_angle (measured_angle),
		.cmd            (cmd),
		.drive_value    (drive_value),
		.sliding_value  (sliding_value)
	);

	// Block takes no second angle right after a transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	// A new result appears only from a sample in progress
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised without a sample in progress");

	// Output load is issued only with the output register free
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid && out_stall))
		else $error("output overwritten while stalled");

endmodule

// File: design/stc_ctrl.sv
// Sequencer of the super-twisting controller: handshakes, state machine,
// iteration counter and output valid. Depends on stc_pkg.
module stc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output stc_pkg::cmd_t       cmd
);

	stc_pkg::state_t                 state_q;
	stc_pkg::state_t                 state_next;
	logic [stc_pkg::CNT_W-1:0]       iter_cnt_q;
	logic                            out_valid_q;
	logic                            out_free;
	logic                            last_iter;

	assign out_free  = !out_valid_q || !out_stall;
	assign last_iter = (iter_cnt_q == stc_pkg::CNT_W'(stc_pkg::ITER_STEPS - 1));
	assign in_stall  = (state_q != stc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// Decode state into datapath commands
	always_comb begin
		cmd            = '0;
		cmd.load_angle = (state_q == stc_pkg::ST_IDLE) && in_valid;
		cmd.calc_sigma = (state_q == stc_pkg::ST_SIGMA);
		cmd.prep       = (state_q == stc_pkg::ST_PREP);
		cmd.iterate    = (state_q == stc_pkg::ST_ITER);
		cmd.update_w   = (state_q == stc_pkg::ST_UPDW);
		cmd.load_out   = (state_q == stc_pkg::ST_DRIVE) && out_free;
	end

	// Advance through one sample
	always_comb begin
		state_next = state_q;
		case (state_q)
			stc_pkg::ST_IDLE: begin
				if (in_valid) state_next = stc_pkg::ST_SIGMA;
			end
			stc_pkg::ST_SIGMA: state_next = stc_pkg::ST_PREP;
			stc_pkg::ST_PREP:  state_next = stc_pkg::ST_ITER;
			stc_pkg::ST_ITER: begin
				if (last_iter) state_next = stc_pkg::ST_UPDW;
			end
			stc_pkg::ST_UPDW:  state_next = stc_pkg::ST_DRIVE;
			stc_pkg::ST_DRIVE: begin
				if (out_free) state_next = stc_pkg::ST_IDLE;
			end
			default: state_next = stc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stc_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Count root iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_cnt_q <= '0;
		end else if (state_q == stc_pkg::ST_ITER) begin
			iter_cnt_q <= last_iter ? '0 : iter_cnt_q + 1'b1;
		end else begin
			iter_cnt_q <= '0;
		end
	end

	// Hold the result until the downstream transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: design/stc_dp.sv
// Datapath of the super-twisting controller: configuration registers,
// sigma, integral term, bit-serial root and reciprocal divide-by-ten. Depends on stc_pkg.
module stc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic signed [15:0]   measured_angle,
	input  stc_pkg::cmd_t        cmd,
	output logic signed [31:0]   drive_value,
	output logic signed [31:0]   sliding_value
);

	logic [15:0] setpoint_q;
	logic [15:0] gain_p_q;
	logic [15:0] gain_d_q;
	logic [15:0] offset_q;
	logic [15:0] sample_period_q;
	logic [31:0] integral_q;

	logic signed [15:0]             angle_q;
	logic [31:0]                    sigma_q;
	logic [31:0]                    raw_q;
	logic [stc_pkg::RAD_W-1:0]      rad_q;
	logic [stc_pkg::ROOT_W-1:0]     root_q;
	logic [stc_pkg::ROOT_W:0]       rem_q;
	logic [stc_pkg::DIV_W-1:0]      dq_q;
	logic [stc_pkg::DIV_W-1:0]      step_q;
	logic [31:0]                    drive_q;
	logic [31:0]                    sliding_q;

	logic signed [16:0]             diff;
	logic signed [33:0]             prod;
	logic signed [34:0]             sig_sum;
	logic [31:0]                    mag;
	logic [47:0]                    rad_prod;
	logic [35:0]                    raw11;
	logic [35:0]                    raw_biased;
	logic                           sig_pos;
	logic                           sig_neg;
	logic [stc_pkg::ROOT_W+2:0]     rem_sh;
	logic [stc_pkg::ROOT_W+1:0]     trial;
	logic                           root_ge;
	logic [stc_pkg::ROOT_W+2:0]     rem_sub;
	logic [2*stc_pkg::DIV_W-1:0]    step_prod;
	logic signed [34:0]             w_sum;
	logic signed [34:0]             d_sum;

	// Write configuration; ignore indexes past the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q      <= '0;
			gain_p_q        <= '0;
			gain_d_q        <= '0;
			offset_q        <= '0;
			sample_period_q <= stc_pkg::SAMPLE_PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				stc_pkg::REG_SETPOINT:      setpoint_q      <= cfg_data;
				stc_pkg::REG_GAIN_P:        gain_p_q        <= cfg_data;
				stc_pkg::REG_GAIN_D:        gain_d_q        <= cfg_data;
				stc_pkg::REG_OFFSET:        offset_q        <= cfg_data;
				stc_pkg::REG_SAMPLE_PERIOD: sample_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sigma: offset widened to Q.16 plus gain_d times the angle error
	assign diff    = 17'(angle_q) - 17'($signed(setpoint_q));
	assign prod    = $signed({1'b0, gain_d_q}) * diff;
	assign sig_sum = 35'(prod) + 35'($signed({offset_q, 8'h00}));

	assign sig_neg = sigma_q[31];
	assign sig_pos = !sigma_q[31] && (sigma_q != '0);

	// Magnitude and root radicand; step numerator times eleven plus bias
	assign mag        = sig_neg ? (~sigma_q + 32'd1) : sigma_q;
	assign rad_prod   = {32'd0, gain_p_q} * {16'd0, mag};
	assign raw11      = {4'd0, raw_q} + {3'd0, raw_q, 1'b0} + {1'b0, raw_q, 3'b000};
	assign raw_biased = raw11 + stc_pkg::STEP_BIAS;

	// One root digit: bring down two radicand bits, try (root << 2) | 1
	assign rem_sh  = {rem_q, rad_q[stc_pkg::RAD_W-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign root_ge = rem_sh >= {1'b0, trial};
	assign rem_sub = root_ge ? (rem_sh - {1'b0, trial}) : rem_sh;

	// Divide the step dividend by ten with a reciprocal multiply
	assign step_prod = dq_q * stc_pkg::RECIP_TEN;

	// Integral update and drive sums
	assign w_sum = sig_pos ? (35'($signed(integral_q)) - 35'({1'b0, step_q}))
	             : sig_neg ? (35'($signed(integral_q)) + 35'({1'b0, step_q}))
	             : 35'($signed(integral_q));
	assign d_sum = sig_pos ? (35'($signed(integral_q)) - 35'({1'b0, root_q}))
	             : sig_neg ? (35'($signed(integral_q)) + 35'({1'b0, root_q}))
	             : 35'($signed(integral_q));

	// Integral state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
		end else if (cmd.update_w) begin
			integral_q <= stc_pkg::sat35(w_sum);
		end
	end

	// Per-sample working registers
	always_ff @(posedge clk) begin
		if (cmd.load_angle) begin
			angle_q <= measured_angle;
		end
		if (cmd.calc_sigma) begin
			sigma_q <= stc_pkg::sat35(sig_sum);
			raw_q   <= {16'd0, sample_period_q} * {16'd0, gain_p_q};
		end
		if (cmd.prep) begin
			rad_q  <= {rad_prod, 8'h00};
			root_q <= '0;
			rem_q  <= '0;
			dq_q   <= raw_biased[35:8];
		end else if (cmd.iterate) begin
			rad_q  <= {rad_q[stc_pkg::RAD_W-3:0], 2'b00};
			root_q <= {root_q[stc_pkg::ROOT_W-2:0], root_ge};
			rem_q  <= rem_sub[stc_pkg::ROOT_W:0];
			step_q <= stc_pkg::DIV_W'(step_prod >> stc_pkg::RECIP_SHIFT);
		end
		if (cmd.load_out) begin
			drive_q   <= stc_pkg::sat35(d_sum);
			sliding_q <= sigma_q;
		end
	end

	assign drive_value   = $signed(drive_q);
	assign sliding_value = $signed(sliding_q);

endmodule
